// ----- hdl/gak_pkg.sv -----
package gak_pkg;

  localparam int unsigned AngleFracBits = 16;
  localparam int unsigned CovFracBits   = 24;
  localparam int unsigned DataW         = 32;
  localparam int unsigned CfgW          = 31;
  localparam int unsigned MsW           = 10;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned ProdW         = 2 * DataW;
  localparam int unsigned DivStepW      = 6;

  localparam logic [CfgIdxW-1:0] CFG_QA = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_QG = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_R  = 2'd2;

  localparam logic [CfgW-1:0] QA_RESET = 31'd16777;
  localparam logic [CfgW-1:0] QG_RESET = 31'd50332;
  localparam logic [CfgW-1:0] R_RESET  = 31'd8388608;
  localparam logic signed [DataW-1:0] COV_ONE = 32'sd16777216;

  // dt = floor(ms * 2^24 / 1000) = floor(ms * 2^21 / 125)
  //    = ms * 16777 + floor(ms * 27 / 125), since 2^21 = 125 * 16777 + 27
  // floor(y / 125) = (y * ceil(2^22 / 125)) >> 22, exact for y < 27648
  localparam int unsigned DtInt        = 16777;
  localparam int unsigned DtFrac       = 27;
  localparam int unsigned DtFracW      = 15;
  localparam int unsigned DtRecip      = 33555;
  localparam int unsigned DtRecipShift = 22;

  // datapath commands
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,      // latch item, compute dt and rate
    OP_ANG_PRED,  // angle += rate*dt
    OP_T0,        // cov_aa += qmul(t0,dt)
    OP_T1A,       // cov_ab += qmul(t1,dt)
    OP_T1B,       // cov_ba += qmul(t1,dt)
    OP_T3,        // cov_bb += qmul(qg,dt)
    OP_DIV_START,
    OP_DIV_STEP,
    OP_C_AA,      // cov_aa -= k0*p00
    OP_C_AB,
    OP_C_BA,
    OP_C_BB,
    OP_C_ANG,
    OP_C_BIAS,
    OP_DONE
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PRED, ST_DIV, ST_CORR, ST_OUT
  } state_e;

  typedef struct packed {
    op_e  op;
    logic div_sel;  // 0: k0 numerator p00, 1: k1 numerator p10
  } cmd_t;

  typedef struct packed {
    logic e_pos;
    logic div_done;
  } stat_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [ProdW-1:0] v);
    logic signed [DataW-1:0] r;
    if (v > 64'sh000000007fffffff) r = 32'sh7fffffff;
    else if (v < -64'sh0000000080000000) r = 32'sh80000000;
    else r = v[DataW-1:0];
    return r;
  endfunction

endpackage

// ----- hdl/gak_if.sv -----
interface gak_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [gak_pkg::DataW-1:0]   angle_meas;
  logic signed [gak_pkg::DataW-1:0]   rate_meas;
  logic        [gak_pkg::MsW-1:0]     loop_ms;
  modport source (output valid, angle_meas, rate_meas, loop_ms, input ready);
  modport sink   (input valid, angle_meas, rate_meas, loop_ms, output ready);
endinterface

interface gak_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [gak_pkg::DataW-1:0]   angle_est;
  logic signed [gak_pkg::DataW-1:0]   rate_est;
  modport source (output valid, angle_est, rate_est, input ready);
  modport sink   (input valid, angle_est, rate_est, output ready);
endinterface

// ----- hdl/gak_ctrl.sv -----
module gak_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  gak_pkg::stat_t  stat_i,
  output gak_pkg::cmd_t   cmd_o
);

  gak_pkg::state_e state_q, state_d;
  logic [2:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gak_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    step_d         = step_q;
    cmd_o.op       = gak_pkg::OP_NONE;
    cmd_o.div_sel  = 1'b0;
    in_ready_o     = 1'b0;
    out_valid_o    = 1'b0;
    case (state_q)
      gak_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = gak_pkg::OP_LOAD;
          state_d  = gak_pkg::ST_PRED;
          step_d   = '0;
        end
      end
      gak_pkg::ST_PRED: begin
        step_d = step_q + 3'd1;
        case (step_q)
          3'd0: cmd_o.op = gak_pkg::OP_ANG_PRED;
          3'd1: cmd_o.op = gak_pkg::OP_T0;
          3'd2: cmd_o.op = gak_pkg::OP_T1A;
          3'd3: cmd_o.op = gak_pkg::OP_T1B;
          3'd4: cmd_o.op = gak_pkg::OP_T3;
          default: begin
            // cov_aa settled: decide whether to correct
            if (stat_i.e_pos) begin
              cmd_o.op = gak_pkg::OP_DIV_START;
              state_d  = gak_pkg::ST_DIV;
              step_d   = '0;
            end else begin
              cmd_o.op = gak_pkg::OP_DONE;
              state_d  = gak_pkg::ST_OUT;
            end
          end
        endcase
      end
      gak_pkg::ST_DIV: begin
        cmd_o.div_sel = step_q[0];
        if (stat_i.div_done) begin
          if (step_q[0]) begin
            state_d = gak_pkg::ST_CORR;
            step_d  = '0;
          end else begin
            cmd_o.op = gak_pkg::OP_DIV_START;
            cmd_o.div_sel = 1'b1;
            step_d   = 3'd1;
          end
        end else begin
          cmd_o.op = gak_pkg::OP_DIV_STEP;
        end
      end
      gak_pkg::ST_CORR: begin
        step_d = step_q + 3'd1;
        case (step_q)
          3'd0: cmd_o.op = gak_pkg::OP_C_AA;
          3'd1: cmd_o.op = gak_pkg::OP_C_AB;
          3'd2: cmd_o.op = gak_pkg::OP_C_BA;
          3'd3: cmd_o.op = gak_pkg::OP_C_BB;
          // bias first: both use the innovation on the predicted angle
          3'd4: cmd_o.op = gak_pkg::OP_C_BIAS;
          3'd5: cmd_o.op = gak_pkg::OP_C_ANG;
          default: begin
            cmd_o.op = gak_pkg::OP_DONE;
            state_d  = gak_pkg::ST_OUT;
          end
        endcase
      end
      gak_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = gak_pkg::ST_IDLE;
      end
      default: state_d = gak_pkg::ST_IDLE;
    endcase
  end

  a_out_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gak_pkg::ST_OUT) |-> !in_ready_o) else $error("ready while holding result");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");
  a_load_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == gak_pkg::ST_PRED)) else $error("bad load");

endmodule

// ----- hdl/gak_dp.sv -----
module gak_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gak_pkg::cmd_t                     cmd_i,
  output gak_pkg::stat_t                    stat_o,
  input  logic                              cfg_we_i,
  input  logic [gak_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [gak_pkg::CfgW-1:0]          cfg_data_i,
  input  logic signed [gak_pkg::DataW-1:0]  angle_meas_i,
  input  logic signed [gak_pkg::DataW-1:0]  rate_meas_i,
  input  logic        [gak_pkg::MsW-1:0]    loop_ms_i,
  output logic signed [gak_pkg::DataW-1:0]  angle_est_o,
  output logic signed [gak_pkg::DataW-1:0]  rate_est_o
);

  localparam int unsigned W  = gak_pkg::DataW;
  localparam int unsigned PW = gak_pkg::ProdW;
  localparam int unsigned F  = gak_pkg::CovFracBits;
  // dividend |P|*2^24 fits in 56 bits
  localparam int unsigned NW = W + F;
  localparam int unsigned DW = W + 2;  // |E| up to ~2^32
  localparam int unsigned FqW = 2 * gak_pkg::DtFracW + 1;

  logic [gak_pkg::CfgW-1:0] qa_q, qg_q, r_q;
  logic signed [W-1:0] ang_q, bias_q, aa_q, ab_q, ba_q, bb_q;
  logic signed [W-1:0] meas_q, rate_q, dt_q, k0_q, k1_q, p00_q, p01_q;

  // divider
  logic [NW-1:0]  quo_q, quo_d;
  logic [DW-1:0]  rem_q, rem_d;
  logic [DW-1:0]  den_q;
  logic           neg_q;
  logic [gak_pkg::DivStepW-1:0] cnt_q;

  // shared multiplier
  logic signed [W-1:0]  ma, mb;
  logic signed [PW-1:0] prod, prod_sh;
  logic signed [W-1:0]  acc;
  logic                 sub;

  logic signed [PW-1:0] e_full;
  logic signed [W-1:0]  rate_n, t0, t1, err;
  logic [gak_pkg::DtFracW-1:0] dt_fr;
  logic [FqW-1:0]              dt_fq;
  logic [W-1:0]                dt_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qa_q <= gak_pkg::QA_RESET;
      qg_q <= gak_pkg::QG_RESET;
      r_q  <= gak_pkg::R_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gak_pkg::CFG_QA: qa_q <= cfg_data_i;
        gak_pkg::CFG_QG: qg_q <= cfg_data_i;
        gak_pkg::CFG_R:  r_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rate_n = gak_pkg::sat32(PW'(rate_meas_i) - PW'(bias_q));
  assign t0 = gak_pkg::sat32(PW'({1'b0, qa_q}) - PW'(ab_q) - PW'(ba_q));
  assign t1 = gak_pkg::sat32(-PW'(bb_q));
  assign err = gak_pkg::sat32(PW'(meas_q) - PW'(ang_q));
  assign e_full = PW'(aa_q) + PW'({1'b0, r_q});
  assign stat_o.e_pos = (e_full > 0);
  assign stat_o.div_done = (cnt_q == '0);
  // dt by constant multiplies: integer part plus reciprocal of the remainder term
  assign dt_fr = gak_pkg::DtFracW'(loop_ms_i) * gak_pkg::DtFracW'(gak_pkg::DtFrac);
  assign dt_fq = FqW'(dt_fr) * FqW'(gak_pkg::DtRecip);
  assign dt_n  = W'(loop_ms_i) * W'(gak_pkg::DtInt) + W'(dt_fq >> gak_pkg::DtRecipShift);

  always_comb begin
    ma  = dt_q;
    mb  = rate_q;
    acc = ang_q;
    sub = 1'b0;
    case (cmd_i.op)
      gak_pkg::OP_ANG_PRED: begin mb = rate_q; acc = ang_q; end
      gak_pkg::OP_T0:   begin mb = t0; acc = aa_q; end
      gak_pkg::OP_T1A:  begin mb = t1; acc = ab_q; end
      gak_pkg::OP_T1B:  begin mb = t1; acc = ba_q; end
      gak_pkg::OP_T3:   begin mb = $signed({1'b0, qg_q}); acc = bb_q; end
      gak_pkg::OP_C_AA: begin ma = k0_q; mb = p00_q; acc = aa_q; sub = 1'b1; end
      gak_pkg::OP_C_AB: begin ma = k0_q; mb = p01_q; acc = ab_q; sub = 1'b1; end
      gak_pkg::OP_C_BA: begin ma = k1_q; mb = p00_q; acc = ba_q; sub = 1'b1; end
      gak_pkg::OP_C_BB: begin ma = k1_q; mb = p01_q; acc = bb_q; sub = 1'b1; end
      gak_pkg::OP_C_ANG:  begin ma = k0_q; mb = err; acc = ang_q; end
      gak_pkg::OP_C_BIAS: begin ma = k1_q; mb = err; acc = bias_q; end
      default: ;
    endcase
  end

  assign prod    = PW'(ma) * PW'(mb);
  assign prod_sh = prod >>> F;  // floor

  logic signed [W-1:0] upd;
  assign upd = gak_pkg::sat32(sub ? (PW'(acc) - prod_sh) : (PW'(acc) + prod_sh));

  // restoring divider step
  logic [DW:0] trial;
  assign trial = {rem_q, quo_q[NW-1]} - {1'b0, den_q};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (!trial[DW]) begin
      rem_d = trial[DW-1:0];
      quo_d = {quo_q[NW-2:0], 1'b1};
    end else begin
      rem_d = {rem_q[DW-2:0], quo_q[NW-1]};
      quo_d = {quo_q[NW-2:0], 1'b0};
    end
  end

  logic signed [W-1:0] num_sel;
  logic        [W-1:0] num_abs;
  logic signed [PW-1:0] q_signed;
  assign num_sel = cmd_i.div_sel ? ba_q : aa_q;
  assign num_abs = num_sel[W-1] ? W'(-num_sel) : num_sel;
  assign q_signed = neg_q ? -PW'({1'b0, quo_q}) : PW'({1'b0, quo_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_q  <= '0;
      bias_q <= '0;
      aa_q   <= gak_pkg::COV_ONE;
      ab_q   <= '0;
      ba_q   <= '0;
      bb_q   <= gak_pkg::COV_ONE;
      cnt_q  <= '0;
    end else begin
      case (cmd_i.op)
        gak_pkg::OP_ANG_PRED, gak_pkg::OP_C_ANG: ang_q <= upd;
        gak_pkg::OP_T0, gak_pkg::OP_C_AA:        aa_q  <= upd;
        gak_pkg::OP_T1A, gak_pkg::OP_C_AB:       ab_q  <= upd;
        gak_pkg::OP_T1B, gak_pkg::OP_C_BA:       ba_q  <= upd;
        gak_pkg::OP_T3, gak_pkg::OP_C_BB:        bb_q  <= upd;
        gak_pkg::OP_C_BIAS:                      bias_q <= upd;
        gak_pkg::OP_DIV_START: cnt_q <= gak_pkg::DivStepW'(NW);
        gak_pkg::OP_DIV_STEP:  cnt_q <= cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      gak_pkg::OP_LOAD: begin
        meas_q <= angle_meas_i;
        rate_q <= rate_n;
        dt_q   <= dt_n;
      end
      gak_pkg::OP_DIV_START: begin
        if (cmd_i.div_sel) k0_q <= gak_pkg::sat32(q_signed);
        quo_q <= {num_abs, {F{1'b0}}};
        rem_q <= '0;
        den_q <= DW'(e_full);
        neg_q <= num_sel[W-1];
        p00_q <= aa_q;
        p01_q <= ab_q;
      end
      gak_pkg::OP_DIV_STEP: begin
        quo_q <= quo_d;
        rem_q <= rem_d;
      end
      default: ;
    endcase
    if (cmd_i.op == gak_pkg::OP_C_AA) k1_q <= gak_pkg::sat32(q_signed);
  end

  assign angle_est_o = ang_q;
  assign rate_est_o  = rate_q;

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == gak_pkg::OP_DIV_STEP) |-> (cnt_q != '0)) else $error("divider overrun");
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == gak_pkg::OP_DIV_START) |=> (cnt_q == gak_pkg::DivStepW'(NW)))
    else $error("divider not loaded");
  a_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == gak_pkg::OP_DIV_START && !cmd_i.div_sel) |-> stat_o.e_pos)
    else $error("divide by non-positive E");

endmodule

// ----- hdl/gyro_accel_kalman_angle.sv -----
// Kalman angle filter: one item in, one result out.
// Flow: predict; unless the correct step is skipped, two 56-step restoring divides
//   and then 6 multiplies follow before the result is held.
// Throughput: one item at a time; the next item is taken the cycle after the result leaves.
// Reset (rst_ni low, async): state zero, covariance diagonal 1.0, noise registers
//   to their defaults (Qa 0.001, Qg 0.003, R 0.5).
module gyro_accel_kalman_angle (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  gak_in_if.sink                            in_if,
  gak_out_if.source                         out_if,
  input  logic                              cfg_we_i,
  input  logic [gak_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [gak_pkg::CfgW-1:0]          cfg_data_i
);

  gak_pkg::cmd_t  cmd;
  gak_pkg::stat_t stat;

  // sequencer: predict, then if E is positive two gain divides and correct, then hold the result
  gak_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // state, one shared 32x32 multiplier and a serial divider
  gak_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .angle_meas_i (in_if.angle_meas),
    .rate_meas_i  (in_if.rate_meas),
    .loop_ms_i    (in_if.loop_ms),
    .angle_est_o  (out_if.angle_est),
    .rate_est_o   (out_if.rate_est)
  );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DW = gak_pkg::DataW;
  localparam int unsigned PW = gak_pkg::ProdW;

  typedef struct packed {
    logic signed [DW-1:0]           angle_meas;
    logic signed [DW-1:0]           rate_meas;
    logic [gak_pkg::MsW-1:0]        loop_ms;
  } sample_t;

  typedef struct packed {
    logic signed [DW-1:0] angle_est;
    logic signed [DW-1:0] rate_est;
  } estimate_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [gak_pkg::CfgIdxW-1:0] cfg_idx_i = gak_pkg::CFG_QA;
  logic [gak_pkg::CfgW-1:0] cfg_data_i = '0;

  gak_in_if  in_if ();
  gak_out_if out_if ();

  gyro_accel_kalman_angle u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_if     (in_if.sink),
    .out_if    (out_if.source),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // filter state mirrored in the bench
  logic [gak_pkg::CfgW-1:0] qa_m, qg_m, r_m;
  logic signed [DW-1:0] ang_m, bias_m, paa, pab, pba, pbb;

  sample_t   sample_q[$];
  estimate_t estimate_q[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  bit        calm = 1'b0;   // no idling on either side while set
  bit        in_acc = 1'b0; // item taken at the last rising edge

  function automatic logic signed [DW-1:0] clip(input logic signed [PW+8:0] v);
    if (v > 73'sd2147483647) return 32'sh7fffffff;
    if (v < -73'sd2147483648) return 32'sh80000000;
    return v[DW-1:0];
  endfunction

  // product scaled back by 2^24, floor rounding (>>> on signed is a floor)
  function automatic logic signed [PW-1:0] qprod(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b);
    return p >>> gak_pkg::CovFracBits;
  endfunction

  function automatic estimate_t kalman_update(input sample_t s);
    logic signed [DW-1:0] dt, rate, t0, t1, t3, k0, k1, p00, p01, err;
    logic signed [PW+8:0] e, num;
    estimate_t r;
    dt   = DW'((PW'(s.loop_ms) << gak_pkg::CovFracBits) / 1000);
    rate = clip($signed({{41{s.rate_meas[31]}}, s.rate_meas}) - bias_m);
    ang_m = clip(ang_m + qprod(rate, dt));
    t0 = clip($signed({42'b0, qa_m}) - pab - pba);
    t1 = clip(-$signed({{41{pbb[31]}}, pbb}));
    t3 = clip($signed({42'b0, qg_m}));
    paa = clip(paa + qprod(t0, dt));
    pab = clip(pab + qprod(t1, dt));
    pba = clip(pba + qprod(t1, dt));
    pbb = clip(pbb + qprod(t3, dt));
    e = paa + $signed({42'b0, r_m});
    if (e > 0) begin
      num = paa; k0 = clip((num <<< gak_pkg::CovFracBits) / e);
      num = pba; k1 = clip((num <<< gak_pkg::CovFracBits) / e);
      p00 = paa;
      p01 = pab;
      err = clip(PW'($signed(s.angle_meas)) - PW'(ang_m));
      paa = clip(paa - qprod(k0, p00));
      pab = clip(pab - qprod(k0, p01));
      pba = clip(pba - qprod(k1, p00));
      pbb = clip(pbb - qprod(k1, p01));
      ang_m  = clip(ang_m + qprod(k0, err));
      bias_m = clip(bias_m + qprod(k1, err));
    end
    r.angle_est = ang_m;
    r.rate_est  = rate;
    return r;
  endfunction

  // driver: pops pending items, predicts at acceptance
  initial begin
    in_if.valid = 1'b0;
    in_if.angle_meas = '0;
    in_if.rate_meas = '0;
    in_if.loop_ms = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    in_acc = in_if.valid && in_if.ready;
    if (in_if.valid && in_if.ready) begin
      estimate_q.push_back(kalman_update(sample_q.pop_front()));
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_acc) begin
      // hold the item until taken
    end else if (sample_q.size() > 0 && (calm || $urandom_range(99) >= 8)) begin
      // the taken item is already popped: the head is the next one
      sample_t nx;
      nx = sample_q[0];
      in_if.valid      <= 1'b1;
      in_if.angle_meas <= nx.angle_meas;
      in_if.rate_meas  <= nx.rate_meas;
      in_if.loop_ms    <= nx.loop_ms;
    end else begin
      in_if.valid <= 1'b0;
    end
    out_if.ready <= rst_ni && (calm || $urandom_range(99) >= 8);
  end

  // monitor: check each result against the oldest expectation
  always @(posedge clk_i) begin
    if (out_if.valid && out_if.ready) begin
      if (estimate_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %h",
                                       out_if.angle_est, out_if.rate_est);
      end else begin
        estimate_t x;
        x = estimate_q.pop_front();
        if (x.angle_est !== out_if.angle_est || x.rate_est !== out_if.rate_est) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: angle exp %h got %h, rate exp %h got %h",
                     x.angle_est, out_if.angle_est, x.rate_est, out_if.rate_est);
        end
      end
    end
  end

  // watchdog on cycles with no accepted item or result
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic add_sample(input logic [31:0] a, input logic [31:0] r,
                            input logic [gak_pkg::MsW-1:0] ms);
    sample_t s;
    s.angle_meas = a;
    s.rate_meas = r;
    s.loop_ms = ms;
    sample_q.push_back(s);
  endtask

  task automatic drain();
    while (sample_q.size() > 0 || in_if.valid || estimate_q.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // config writes happen only while idle
  task automatic write_reg(input logic [gak_pkg::CfgIdxW-1:0] idx,
                           input logic [gak_pkg::CfgW-1:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == gak_pkg::CFG_QA) qa_m = v;
    else if (idx == gak_pkg::CFG_QG) qg_m = v;
    else if (idx == gak_pkg::CFG_R) r_m = v;
  endtask

  task automatic random_burst(input int n, input int max_ms);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(9);
      if (pick == 0)
        add_sample($urandom, $urandom, gak_pkg::MsW'($urandom));
      else if (pick == 1)
        add_sample($urandom_range(1) ? 32'h7fffffff : 32'h80000000,
                   $urandom_range(1) ? 32'h7fffffff : 32'h80000000,
                   $urandom_range(1) ? 10'd1023 : 10'd0);
      else  // plausible IMU samples: +-64 deg, +-256 deg/s
        add_sample(32'($signed($urandom_range(8388608)) - 4194304),
                   32'($signed($urandom_range(33554432)) - 16777216),
                   gak_pkg::MsW'($urandom_range(max_ms)));
    end
  endtask

  initial begin
    qa_m = gak_pkg::QA_RESET; qg_m = gak_pkg::QG_RESET; r_m = gak_pkg::R_RESET;
    ang_m = '0; bias_m = '0; pab = '0; pba = '0;
    paa = gak_pkg::COV_ONE; pbb = gak_pkg::COV_ONE;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes, zero dt, large innovation
    add_sample(32'h0, 32'h0, 10'd0);
    add_sample(32'h7fffffff, 32'h7fffffff, 10'd1023);
    add_sample(32'h80000000, 32'h80000000, 10'd1023);
    add_sample(32'h7fffffff, 32'h80000000, 10'd1);
    add_sample(32'h80000000, 32'h7fffffff, 10'd10);
    add_sample(32'h00010000, 32'hffff0000, 10'd5);
    add_sample(32'hffffffff, 32'h00000001, 10'd512);
    add_sample(32'h55555555, 32'haaaaaaaa, 10'h155);
    add_sample(32'haaaaaaaa, 32'h55555555, 10'h2aa);
    drain();

    // zero R with tiny covariance drives E non-positive
    write_reg(gak_pkg::CFG_R, 31'd0);
    write_reg(gak_pkg::CFG_QA, 31'd0);
    add_sample(32'h00100000, 32'h0, 10'd0);
    add_sample(32'h00200000, 32'h00010000, 10'd0);
    add_sample(32'h00300000, 32'h00010000, 10'd20);
    add_sample(32'hfff00000, 32'h0, 10'd1023);
    drain();
    write_reg(gak_pkg::CFG_QA, 31'h7fffffff);
    write_reg(gak_pkg::CFG_QG, 31'h7fffffff);
    write_reg(gak_pkg::CFG_R, 31'h7fffffff);
    add_sample(32'h00050000, 32'h00020000, 10'd1023);
    add_sample(32'h80000000, 32'h7fffffff, 10'd1023);
    drain();
    write_reg(2'd3, 31'h1234);   // index out of range: ignored

    // random phases over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(gak_pkg::CFG_QA, gak_pkg::QA_RESET);
                 write_reg(gak_pkg::CFG_QG, gak_pkg::QG_RESET);
                 write_reg(gak_pkg::CFG_R, gak_pkg::R_RESET); end
        1: begin write_reg(gak_pkg::CFG_R, 31'd1); write_reg(gak_pkg::CFG_QA, 31'd0); end
        5: begin write_reg(gak_pkg::CFG_QA, gak_pkg::QA_RESET);
                 write_reg(gak_pkg::CFG_QG, gak_pkg::QG_RESET);
                 write_reg(gak_pkg::CFG_R, gak_pkg::R_RESET); end
        default: begin
          write_reg(gak_pkg::CFG_QA, gak_pkg::CfgW'($urandom));
          write_reg(gak_pkg::CFG_QG, gak_pkg::CfgW'($urandom_range(33554432)));
          write_reg(gak_pkg::CFG_R, gak_pkg::CfgW'($urandom_range(134217728, 1)));
        end
      endcase
      calm = (ph == 3);
      random_burst(180, (ph == 4) ? 1023 : 50);
      drain();
    end
    calm = 1'b0;

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- gyro_accel_kalman_angle.f -----
hdl/gak_pkg.sv
hdl/gak_if.sv
hdl/gak_ctrl.sv
hdl/gak_dp.sv
hdl/gyro_accel_kalman_angle.sv
verif/tb.sv
